[src/tbe_pkg.sv]
package tbe_pkg;

  localparam int RATE_W     = 24;
  localparam int TIME_W     = 40;
  localparam int ANG_W      = 32;
  localparam int FRAC_BITS  = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int SWEEP_W    = 33;
  localparam int QUOT_W     = 40;
  localparam int DIV_W      = RATE_W + FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_RAPID_RATE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_FEED = 8'd1;

  localparam logic [31:0]       KINV_Q32   = 32'd2608131496;
  localparam logic [31:0]       TWO_PI_Q29 = 32'd3373259426;
  localparam logic [12:0]       MS_SCALE   = 13'd6000;
  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

  typedef struct packed {
    logic              is_arc;
    logic              clockwise;
    logic              last;
    logic [RATE_W-1:0] rate;
  } job_ctl_t;

  // Arctangent of 2^-i in turns, 2^32 being one full turn.
  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[src/tbe_if.sv]
interface tbe_in_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic                 is_arc;
  logic                 clockwise;
  logic                 is_rapid;
  logic [23:0]          feed;
  logic                 last_segment;

  modport source(output valid, start_x, start_y, end_x, end_y, center_x, center_y,
                 is_arc, clockwise, is_rapid, feed, last_segment, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, center_x, center_y,
               is_arc, clockwise, is_rapid, feed, last_segment, output ready);
endinterface

interface tbe_out_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic [39:0]          total_time_ms;
  logic signed [CW-1:0] min_x;
  logic signed [CW-1:0] min_y;
  logic signed [CW-1:0] max_x;
  logic signed [CW-1:0] max_y;

  modport source(output valid, total_time_ms, min_x, min_y, max_x, max_y, input ready);
  modport sink(input valid, total_time_ms, min_x, min_y, max_x, max_y, output ready);
endinterface

interface tbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[src/tbe_front.sv]
module tbe_front
  import tbe_pkg::*;
#(
  parameter int CW = 32,
  parameter int DW = 10 * CW + 6
) (
  input  logic           clk,
  input  logic           rst_n,
  tbe_in_if.sink         in_ch,
  tbe_cfg_if.sink        cfg_ch,
  input  logic           q_full,
  output logic           push,
  output job_ctl_t       push_ctl,
  output logic [DW-1:0]  push_data
);

  localparam int DIFW = CW + 1;
  localparam logic signed [CW-1:0] POS_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] NEG_MAX = {1'b1, {(CW - 1){1'b0}}};

  logic [RATE_W-1:0] rapid_r, fallback_r;
  logic signed [CW-1:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic signed [CW-1:0] min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt;
  logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [DIFW-1:0] sc_x, sc_y, es_x, es_y, ec_x, ec_y;
  logic [RATE_W-1:0] base_rate;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign push         = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rapid_r    <= '0;
      fallback_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_RAPID_RATE) rapid_r <= cfg_ch.data[RATE_W-1:0];
      if (cfg_ch.index == REG_FALLBACK_FEED) fallback_r <= cfg_ch.data[RATE_W-1:0];
    end
  end

  // Both end points widen the box.
  always_comb begin
    lo_x = (in_ch.end_x < in_ch.start_x) ? in_ch.end_x : in_ch.start_x;
    hi_x = (in_ch.end_x > in_ch.start_x) ? in_ch.end_x : in_ch.start_x;
    lo_y = (in_ch.end_y < in_ch.start_y) ? in_ch.end_y : in_ch.start_y;
    hi_y = (in_ch.end_y > in_ch.start_y) ? in_ch.end_y : in_ch.start_y;
    min_x_nxt = (lo_x < min_x_r) ? lo_x : min_x_r;
    min_y_nxt = (lo_y < min_y_r) ? lo_y : min_y_r;
    max_x_nxt = (hi_x > max_x_r) ? hi_x : max_x_r;
    max_y_nxt = (hi_y > max_y_r) ? hi_y : max_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= POS_MAX;
      min_y_r <= POS_MAX;
      max_x_r <= NEG_MAX;
      max_y_r <= NEG_MAX;
    end else if (push) begin
      if (in_ch.last_segment) begin
        min_x_r <= POS_MAX;
        min_y_r <= POS_MAX;
        max_x_r <= NEG_MAX;
        max_y_r <= NEG_MAX;
      end else begin
        min_x_r <= min_x_nxt;
        min_y_r <= min_y_nxt;
        max_x_r <= max_x_nxt;
        max_y_r <= max_y_nxt;
      end
    end
  end

  always_comb begin
    sc_x = DIFW'(in_ch.start_x) - DIFW'(in_ch.center_x);
    sc_y = DIFW'(in_ch.start_y) - DIFW'(in_ch.center_y);
    es_x = DIFW'(in_ch.end_x) - DIFW'(in_ch.start_x);
    es_y = DIFW'(in_ch.end_y) - DIFW'(in_ch.start_y);
    ec_x = DIFW'(in_ch.end_x) - DIFW'(in_ch.center_x);
    ec_y = DIFW'(in_ch.end_y) - DIFW'(in_ch.center_y);
  end

  always_comb begin
    base_rate          = in_ch.is_rapid ? rapid_r : in_ch.feed;
    push_ctl.is_arc    = in_ch.is_arc;
    push_ctl.clockwise = in_ch.clockwise;
    push_ctl.last      = in_ch.last_segment;
    push_ctl.rate      = (base_rate != '0) ? base_rate : fallback_r;
    push_data = {min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt,
                 sc_x, sc_y, es_x, es_y, ec_x, ec_y};
  end

endmodule

[src/tbe_fifo.sv]
module tbe_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count beyond its depth");

endmodule

[src/tbe_mul.sv]
module tbe_mul #(
  parameter int AW = 50,
  parameter int BW = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] p
);

  // Sixteen bits of a per cycle, most significant digit first.
  localparam int ND = (AW + 15) / 16;
  localparam int PW = ND * 16 + BW;
  localparam int CNTW = $clog2(ND + 1);

  logic [ND*16-1:0] a_r;
  logic [BW-1:0]    b_r;
  logic [PW-1:0]    acc_r;
  logic [CNTW-1:0]  cnt_r;
  logic             done_r;
  logic [BW+15:0]   dig_p;

  assign done  = done_r;
  assign p     = acc_r[AW+BW-1:0];
  assign dig_p = a_r[ND*16-1 -: 16] * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(ND);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= (ND * 16)'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      a_r   <= a_r << 16;
      acc_r <= (acc_r << 16) + PW'(dig_p);
    end
  end

endmodule

[src/tbe_back.sv]
module tbe_back
  import tbe_pkg::*;
#(
  parameter int CW     = 32,
  parameter int STAGES = 24,
  parameter int DW     = 10 * CW + 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  job_ctl_t      pop_ctl,
  input  logic [DW-1:0] pop_data,
  output logic          pop,
  tbe_out_if.source     out_ch
);

  localparam int DIFW = CW + 1;
  localparam int XW   = CW + 16;
  localparam int LW   = CW + 18;
  localparam int PW   = LW + SWEEP_W;
  localparam int NW   = (LW + 34 > 77) ? LW + 34 : 77;
  localparam int BOX0 = 6 * DIFW;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_VINIT = 13'b0000000000010,
    S_VITER = 13'b0000000000100,
    S_VEND  = 13'b0000000001000,
    S_GAIN  = 13'b0000000010000,
    S_SCALE = 13'b0000000100000,
    S_SWEEP = 13'b0000001000000,
    S_RATE  = 13'b0000010000000,
    S_SECS  = 13'b0000100000000,
    S_DCHK  = 13'b0001000000000,
    S_DIV   = 13'b0010000000000,
    S_ACC   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  // Which vector goes through the CORDIC, and what its result is for.
  typedef enum logic [1:0] {
    V_RAD  = 2'd0,
    V_LINE = 2'd1,
    V_END  = 2'd2
  } vec_t;

  state_t state_r, state_nxt;
  vec_t   vec_r, vec_nxt;
  job_ctl_t ctl_r, ctl_nxt;
  logic [DW-1:0] data_r, data_nxt;

  logic signed [XW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [ANG_W-1:0]     z_r, z_nxt, a0_r, a0_nxt;
  logic [4:0]           it_r, it_nxt;
  logic [LW-1:0]        r_r, r_nxt, len_r, len_nxt;
  logic [SWEEP_W-1:0]   sweep_r, sweep_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [QUOT_W-1:0]    ns_r, ns_nxt, q_r, q_nxt;
  logic [5:0]           dcnt_r, dcnt_nxt;
  logic [TIME_W-1:0]    t_r, t_nxt, acc_r, acc_nxt;

  logic                 mul_start_r, mul_start_nxt;
  logic [LW-1:0]        mul_a_r, mul_a_nxt;
  logic [SWEEP_W-1:0]   mul_b_r, mul_b_nxt;
  logic                 mul_done;
  logic [PW-1:0]        mul_p;

  logic                 out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]    out_time_r, out_time_nxt;
  logic signed [CW-1:0] out_min_x_r, out_min_y_r, out_max_x_r, out_max_y_r;
  logic signed [CW-1:0] out_min_x_nxt, out_min_y_nxt, out_max_x_nxt, out_max_y_nxt;
  logic                 out_load;

  logic signed [DIFW-1:0] vx, vy;
  logic signed [XW-1:0]   x0, y0, xs, ys;
  logic [LW-1:0]          mag;
  logic [ANG_W-1:0]       sw32;
  logic [DIV_W-1:0]       dvs;
  logic [DIV_W:0]         rem2;
  logic                   ge;

  tbe_mul #(.AW(LW), .BW(SWEEP_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.total_time_ms = out_time_r;
  assign out_ch.min_x         = out_min_x_r;
  assign out_ch.min_y         = out_min_y_r;
  assign out_ch.max_x         = out_max_x_r;
  assign out_ch.max_y         = out_max_y_r;

  assign pop      = (state_r == S_IDLE) && !q_empty;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign mag      = mul_p[32 +: LW];
  assign dvs      = {ctl_r.rate, {FRAC_BITS{1'b0}}};
  assign rem2     = {rem_r, ns_r[QUOT_W-1]};
  assign ge       = rem2 >= {1'b0, dvs};
  assign xs       = cx_r >>> it_r;
  assign ys       = cy_r >>> it_r;

  always_comb begin
    unique case (vec_r)
      V_RAD: begin
        vx = data_r[5*DIFW +: DIFW];
        vy = data_r[4*DIFW +: DIFW];
      end
      V_LINE: begin
        vx = data_r[3*DIFW +: DIFW];
        vy = data_r[2*DIFW +: DIFW];
      end
      default: begin
        vx = data_r[DIFW +: DIFW];
        vy = data_r[0 +: DIFW];
      end
    endcase
    x0   = XW'(vx) <<< FRAC_BITS;
    y0   = XW'(vy) <<< FRAC_BITS;
    sw32 = ctl_r.clockwise ? (a0_r - z_r) : (z_r - a0_r);
  end

  always_comb begin
    state_nxt     = state_r;
    vec_nxt       = vec_r;
    ctl_nxt       = ctl_r;
    data_nxt      = data_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    z_nxt         = z_r;
    a0_nxt        = a0_r;
    it_nxt        = it_r;
    r_nxt         = r_r;
    len_nxt       = len_r;
    sweep_nxt     = sweep_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    ns_nxt        = ns_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    t_nxt         = t_r;
    acc_nxt       = acc_r;
    mul_start_nxt = 1'b0;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_time_nxt  = out_time_r;
    out_min_x_nxt = out_min_x_r;
    out_min_y_nxt = out_min_y_r;
    out_max_x_nxt = out_max_x_r;
    out_max_y_nxt = out_max_y_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          ctl_nxt   = pop_ctl;
          data_nxt  = pop_data;
          vec_nxt   = pop_ctl.is_arc ? V_RAD : V_LINE;
          state_nxt = S_VINIT;
        end
      end
      S_VINIT: begin
        it_nxt = '0;
        if (vx == '0 && vy == '0) begin
          cx_nxt    = '0;
          cy_nxt    = '0;
          z_nxt     = '0;
          state_nxt = S_VEND;
        end else if (vx < 0) begin
          cx_nxt    = -x0;
          cy_nxt    = -y0;
          z_nxt     = 32'h80000000;
          state_nxt = S_VITER;
        end else begin
          cx_nxt    = x0;
          cy_nxt    = y0;
          z_nxt     = '0;
          state_nxt = S_VITER;
        end
      end
      S_VITER: begin
        if (!cy_r[XW-1]) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          z_nxt  = z_r + atan_turn(it_r);
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          z_nxt  = z_r - atan_turn(it_r);
        end
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(STAGES - 1)) state_nxt = S_VEND;
      end
      S_VEND: begin
        mul_start_nxt = 1'b1;
        if (vec_r == V_END) begin
          sweep_nxt = (sw32 == '0) ? {1'b1, {ANG_W{1'b0}}} : SWEEP_W'(sw32);
          mul_a_nxt = r_r;
          mul_b_nxt = SWEEP_W'(TWO_PI_Q29);
          state_nxt = S_SCALE;
        end else begin
          mul_a_nxt = LW'($unsigned(cx_r));
          mul_b_nxt = SWEEP_W'(KINV_Q32);
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        if (mul_done) begin
          if (vec_r == V_RAD) begin
            r_nxt     = mag;
            a0_nxt    = z_r;
            vec_nxt   = (mag == '0) ? V_LINE : V_END;
            state_nxt = S_VINIT;
          end else begin
            len_nxt   = mag;
            state_nxt = S_RATE;
          end
        end
      end
      S_SCALE: begin
        if (mul_done) begin
          mul_start_nxt = 1'b1;
          mul_a_nxt     = mul_p[29 +: LW];
          mul_b_nxt     = sweep_r;
          state_nxt     = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (mul_done) begin
          len_nxt   = mag;
          state_nxt = S_RATE;
        end
      end
      S_RATE: begin
        if (ctl_r.rate != '0) begin
          mul_start_nxt = 1'b1;
          mul_a_nxt     = len_r;
          mul_b_nxt     = SWEEP_W'(MS_SCALE);
          state_nxt     = S_SECS;
        end else begin
          state_nxt = S_ACC;
        end
      end
      S_SECS: begin
        if (mul_done) begin
          n_nxt     = NW'(mul_p) + NW'({ctl_r.rate, {(FRAC_BITS - 1){1'b0}}});
          state_nxt = S_DCHK;
        end
      end
      S_DCHK: begin
        q_nxt    = '0;
        dcnt_nxt = '0;
        if (n_r >= NW'({dvs, {QUOT_W{1'b0}}})) begin
          t_nxt     = TIME_MAX;
          state_nxt = S_ACC;
        end else begin
          rem_nxt   = n_r[QUOT_W +: DIV_W];
          ns_nxt    = n_r[QUOT_W-1:0];
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? DIV_W'(rem2 - {1'b0, dvs}) : rem2[DIV_W-1:0];
        q_nxt    = {q_r[QUOT_W-2:0], ge};
        ns_nxt   = ns_r << 1;
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'(QUOT_W - 1)) begin
          t_nxt     = {q_r[QUOT_W-2:0], ge};
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (ctl_r.rate != '0) begin
          acc_nxt = (t_r >= TIME_MAX - acc_r) ? TIME_MAX : acc_r + t_r;
        end
        state_nxt = ctl_r.last ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = acc_r;
          out_min_x_nxt = data_r[BOX0 + 3*CW +: CW];
          out_min_y_nxt = data_r[BOX0 + 2*CW +: CW];
          out_max_x_nxt = data_r[BOX0 + CW +: CW];
          out_max_y_nxt = data_r[BOX0 +: CW];
          acc_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      mul_start_r <= mul_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vec_r       <= vec_nxt;
    ctl_r       <= ctl_nxt;
    data_r      <= data_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    z_r         <= z_nxt;
    a0_r        <= a0_nxt;
    it_r        <= it_nxt;
    r_r         <= r_nxt;
    len_r       <= len_nxt;
    sweep_r     <= sweep_nxt;
    n_r         <= n_nxt;
    rem_r       <= rem_nxt;
    ns_r        <= ns_nxt;
    q_r         <= q_nxt;
    dcnt_r      <= dcnt_nxt;
    t_r         <= t_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    out_time_r  <= out_time_nxt;
    out_min_x_r <= out_min_x_nxt;
    out_min_y_r <= out_min_y_nxt;
    out_max_x_r <= out_max_x_nxt;
    out_max_y_r <= out_max_y_nxt;
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the completion step");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (acc_r == '0))
    else $error("time total not cleared after the last segment");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VITER) |-> (it_r <= 5'(STAGES - 1)))
    else $error("CORDIC iteration count overran");

endmodule

[src/toolpath_time_and_bounds_estimator.sv]
// Estimates machining time and the bounding box of a toolpath, one segment per
// request. A line costs its Euclidean length, an arc its radius times its swept
// angle (a full turn when both ends coincide, the chord when the radius is zero),
// and the time in milliseconds is length * 6000 / rate, rounded and saturated at
// 2^40 - 1. A request marked last produces one result with the total and the box
// and then starts a fresh toolpath. A front stage takes requests, widens the box,
// forms the coordinate differences and picks the rate; a two-entry queue hands
// them to a back stage which owns one iterative CORDIC (one micro-rotation per
// cycle), a 16-bit-digit multiplier and a 40-step restoring divider. The back
// stage works on one segment at a time: a line makes one CORDIC pass and an arc
// two (the second on the chord for an arc whose start lies on its centre), and
// the last segment of a toolpath adds a completion step, so the CORDIC
// iterations and the divider set the throughput. Segments with no usable rate
// skip the millisecond multiply and the divider. The front keeps accepting while
// the queue has room, and a waiting result holds up the back stage only when
// the next toolpath's result is ready too.
module toolpath_time_and_bounds_estimator
  import tbe_pkg::*;
#(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  tbe_in_if.sink     in_ch,
  tbe_out_if.source  out_ch,
  tbe_cfg_if.sink    cfg_ch
);

  // Queue entry: box snapshot, three difference vectors and the control word.
  localparam int DW = 4 * COORD_WIDTH + 6 * (COORD_WIDTH + 1);
  localparam int CTLW = $bits(job_ctl_t);

  logic            push, pop, q_full, q_empty;
  job_ctl_t        push_ctl, pop_ctl;
  logic [DW-1:0]   push_data, pop_data;
  logic [CTLW+DW-1:0] q_out;

  tbe_front #(.CW(COORD_WIDTH), .DW(DW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_data (push_data)
  );

  tbe_fifo #(.W(CTLW + DW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_data}),
    .pop       (pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign pop_ctl  = job_ctl_t'(q_out[DW +: CTLW]);
  assign pop_data = q_out[DW-1:0];

  tbe_back #(.CW(COORD_WIDTH), .STAGES(CORDIC_STAGES), .DW(DW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .pop_ctl  (pop_ctl),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the toolpath time and bounds estimator. Every
// accepted request is run through a bit-accurate predictor (CORDIC
// vectoring, arc sweep, rate choice, rounded divide with saturation and
// the bounding box). Each toolpath-end result that the block returns is
// checked field by field against the oldest prediction.
module tb;
  import tbe_pkg::*;

  localparam int CW        = 32;
  localparam int STAGES    = 24;
  localparam int HOLD_CYC  = 3000;   // long receiver stall for the pressure test
  localparam int SETTLE    = 1200;   // generous bound on in-flight work

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey, cx, cy;
    logic                 arc, cw, rapid, is_last;
    logic [RATE_W-1:0]    feed;
  } seg_t;

  typedef struct {
    logic [TIME_W-1:0]    dur_ms;
    logic signed [CW-1:0] min_x, min_y, max_x, max_y;
  } summary_t;

  // Arctangent of 2^-i in turns (2^32 per turn), first STAGES entries.
  localparam logic [31:0] ATAN_TBL [STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic clk;
  logic rst_n;

  tbe_in_if  #(.CW(CW)) in_ch ();
  tbe_out_if #(.CW(CW)) out_ch ();
  tbe_cfg_if            cfg_ch ();

  toolpath_time_and_bounds_estimator #(
    .COORD_WIDTH  (CW),
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow of the block's registers and accumulators.
  logic [RATE_W-1:0] rapid_rate_q, fallback_q;
  logic [TIME_W-1:0] job_ms;
  longint            bmin_x, bmin_y, bmax_x, bmax_y;

  summary_t pending_summaries[$];
  int       n_err;
  int       n_seg;
  int       n_paths;
  int       n_checked;
  bit       idle_on;
  bit       hold_req;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void clear_job();
    job_ms = '0;
    bmin_x = 64'sd2147483647;
    bmin_y = 64'sd2147483647;
    bmax_x = -64'sd2147483648;
    bmax_y = -64'sd2147483648;
  endfunction

  // Vectoring CORDIC on a difference scaled by 2^12; the gain is taken out
  // of the magnitude afterwards. A zero vector has zero length and angle.
  function automatic void cordic_polar(input longint dx, input longint dy,
                                       output logic [63:0] mag,
                                       output logic [31:0] ang);
    longint       x, y, xs, ys;
    logic [31:0]  z;
    logic [127:0] p;
    x = dx * 4096;
    y = dy * 4096;
    z = '0;
    if (dx == 0 && dy == 0) begin
      mag = '0;
      ang = '0;
      return;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (y >= 0) begin
        x = x + xs;
        y = y - ys;
        z = z + ATAN_TBL[i];
      end else begin
        x = x - xs;
        y = y + ys;
        z = z - ATAN_TBL[i];
      end
    end
    p   = 128'(x) * 128'(KINV_Q32);
    mag = p[95:32];
    ang = z;
  endfunction

  // Works out the segment length and time, widens the box, and on the last
  // segment of a toolpath queues the summary the block should return.
  function automatic void predict_segment(input seg_t s);
    longint            sx, sy, ex, ey, cx, cy;
    logic [63:0]       len, rad, unused_mag;
    logic [31:0]       a0, a1, sw32;
    logic [32:0]       sweep;
    logic [127:0]      p, num, q;
    logic [RATE_W-1:0] rate;
    logic [TIME_W-1:0] seg_ms;
    summary_t          sm;
    sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey; cx = s.cx; cy = s.cy;
    if (sx < bmin_x) bmin_x = sx;
    if (sy < bmin_y) bmin_y = sy;
    if (sx > bmax_x) bmax_x = sx;
    if (sy > bmax_y) bmax_y = sy;
    if (ex < bmin_x) bmin_x = ex;
    if (ey < bmin_y) bmin_y = ey;
    if (ex > bmax_x) bmax_x = ex;
    if (ey > bmax_y) bmax_y = ey;

    if (s.arc) begin
      cordic_polar(sx - cx, sy - cy, rad, a0);
      if (rad == 0) begin
        // Start on the centre: fall back to the chord.
        cordic_polar(ex - sx, ey - sy, len, a1);
      end else begin
        cordic_polar(ex - cx, ey - cy, unused_mag, a1);
        sw32  = s.cw ? a0 - a1 : a1 - a0;
        sweep = (sw32 == 0) ? 33'h1_0000_0000 : {1'b0, sw32};
        p     = 128'(rad) * 128'(TWO_PI_Q29);
        p     = p >> 29;
        p     = p * 128'(sweep);
        len   = p[95:32];
      end
    end else begin
      cordic_polar(ex - sx, ey - sy, len, a1);
    end

    rate = s.rapid ? rapid_rate_q : s.feed;
    if (rate == 0) rate = fallback_q;
    if (rate != 0) begin
      num    = 128'(len) * 128'(6000) + (128'(rate) << (FRAC_BITS - 1));
      q      = num / (128'(rate) << FRAC_BITS);
      seg_ms = (q >= (128'(1) << TIME_W)) ? TIME_MAX : q[TIME_W-1:0];
      job_ms = (seg_ms >= TIME_MAX - job_ms) ? TIME_MAX : job_ms + seg_ms;
    end

    if (s.is_last) begin
      sm.dur_ms = job_ms;
      sm.min_x  = bmin_x[CW-1:0];
      sm.min_y  = bmin_y[CW-1:0];
      sm.max_x  = bmax_x[CW-1:0];
      sm.max_y  = bmax_y[CW-1:0];
      pending_summaries.push_back(sm);
      n_paths++;
      clear_job();
    end
  endfunction

  // Offers one segment request, possibly after a random gap, and waits
  // until the block takes it.
  task automatic send_segment(input seg_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.start_x      <= s.sx;
    in_ch.start_y      <= s.sy;
    in_ch.end_x        <= s.ex;
    in_ch.end_y        <= s.ey;
    in_ch.center_x     <= s.cx;
    in_ch.center_y     <= s.cy;
    in_ch.is_arc       <= s.arc;
    in_ch.clockwise    <= s.cw;
    in_ch.is_rapid     <= s.rapid;
    in_ch.feed         <= s.feed;
    in_ch.last_segment <= s.is_last;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_segment(s);
    n_seg++;
  endtask

  // Waits until every summary has come back, then lets segments that
  // produce no result finish before anything else changes.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_RAPID_RATE) rapid_rate_q = val[RATE_W-1:0];
    else if (idx == REG_FALLBACK_FEED) fallback_q = val[RATE_W-1:0];
  endtask

  function automatic seg_t make_seg(input int sx, input int sy, input int ex,
                                    input int ey, input int cx, input int cy,
                                    input bit arc, input bit cw, input bit rapid,
                                    input int feed, input bit is_last);
    seg_t s;
    s.sx = sx; s.sy = sy; s.ex = ex; s.ey = ey; s.cx = cx; s.cy = cy;
    s.arc = arc; s.cw = cw; s.rapid = rapid; s.feed = feed[RATE_W-1:0];
    s.is_last = is_last;
    return s;
  endfunction

  function automatic int rand_coord(input int scale);
    case (scale)
      0:       return int'($urandom_range(0, 2000)) - 1000;
      1:       return int'($urandom_range(0, 2_000_000)) - 1_000_000;
      default: return int'($urandom);
    endcase
  endfunction

  // A random segment. Arcs sometimes get the awkward geometries: a closed
  // circle, a start on the centre and an end on the centre.
  function automatic seg_t rand_segment(input bit is_last);
    seg_t s;
    int   scale;
    scale     = $urandom_range(0, 5) < 3 ? 1 : ($urandom_range(0, 1) ? 0 : 2);
    s.sx      = rand_coord(scale);
    s.sy      = rand_coord(scale);
    s.ex      = rand_coord(scale);
    s.ey      = rand_coord(scale);
    s.cx      = rand_coord(scale);
    s.cy      = rand_coord(scale);
    s.arc     = $urandom_range(0, 1);
    s.cw      = $urandom_range(0, 1);
    s.rapid   = $urandom_range(0, 3) == 0;
    s.is_last = is_last;
    case ($urandom_range(0, 11))
      0, 1:    s.feed = '0;
      2:       s.feed = '1;
      3:       s.feed = RATE_W'($urandom_range(1, 20));
      default: s.feed = RATE_W'($urandom);
    endcase
    if (s.arc) begin
      case ($urandom_range(0, 9))
        0: begin s.ex = s.sx; s.ey = s.sy; end
        1: begin s.cx = s.sx; s.cy = s.sy; end
        2: begin s.ex = s.cx; s.ey = s.cy; end
        default: ;
      endcase
    end
    return s;
  endfunction

  // Toolpaths of one to six segments with random content, n_items segments in all.
  task automatic send_random_paths(input int n_items);
    int left, plen;
    left = n_items;
    while (left > 0) begin
      plen = $urandom_range(1, 6);
      if (plen > left) plen = left;
      for (int i = 0; i < plen; i++)
        send_segment(rand_segment(i == plen - 1));
      left -= plen;
    end
  endtask

  // Extremes of every field and the special cases, with both rates at zero
  // first (no time accrues), then at their extremes and at zero again.
  task automatic test_directed();
    send_segment(make_seg(0, 0, 1000, 0, 0, 0, 0, 0, 0, 0, 1));
    send_segment(make_seg(5, 5, 5, 5, 0, 0, 0, 0, 1, 0, 1));
    drain();
    write_reg(REG_RAPID_RATE, 32'hFFFF_FFFF);
    write_reg(REG_FALLBACK_FEED, 32'h0000_0001);
    // Corner to corner with the slowest rate: the total saturates.
    send_segment(make_seg(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 1, 1));
    send_segment(make_seg(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh7FFF_FFFF, -1, -1, 0, 0, 1, 0, 0));
    send_segment(make_seg(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    // Quarter arcs and closed circles both ways, centre start, centre end and a half circle.
    send_segment(make_seg(1000, 0, 0, 1000, 0, 0, 1, 0, 0, 24'hFFFFFF, 0));
    send_segment(make_seg(1000, 0, 0, 1000, 0, 0, 1, 1, 0, 6000, 0));
    send_segment(make_seg(700, 300, 700, 300, 200, -100, 1, 0, 0, 100, 0));
    send_segment(make_seg(700, 300, 700, 300, 200, -100, 1, 1, 0, 0, 0));
    send_segment(make_seg(50, 50, 400, -20, 50, 50, 1, 0, 0, 1234, 0));
    send_segment(make_seg(-300, 0, 100, 100, 100, 100, 1, 1, 1, 99, 0));
    send_segment(make_seg(-1000, 0, 1000, 0, 0, 0, 1, 0, 0, 24'hFFFFFF, 1));
    // Huge arc with full-range centre.
    send_segment(make_seg(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 32'sh8000_0000,
                          32'sh7FFF_FFFF, 1, 1, 0, 1, 1));
    drain();
    write_reg(REG_RAPID_RATE, 32'h0);
    write_reg(REG_FALLBACK_FEED, 32'h0);
    // Rapid with no rapid rate and no fallback adds nothing.
    send_segment(make_seg(0, 0, 9000, 9000, 0, 0, 0, 0, 1, 500, 0));
    send_segment(make_seg(0, 0, 9000, 9000, 0, 0, 0, 0, 0, 500, 1));
    drain();
  endtask

  // Random toolpaths under several register settings, extremes included.
  task automatic test_random_settings();
    logic [31:0] rapids [4] = '{32'h0, 32'h00FF_FFFF, 32'h0, 32'h0000_0000};
    logic [31:0] falls  [4] = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001};
    rapids[3] = $urandom;
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_RAPID_RATE, rapids[k]);
      write_reg(REG_FALLBACK_FEED, falls[k]);
      send_random_paths(80);
      drain();
    end
  endtask

  // The receiver stalls for a long stretch while one-segment toolpaths keep
  // coming, so the block's queue fills and it stops taking requests.
  task automatic test_backpressure();
    write_reg(REG_RAPID_RATE, $urandom_range(1000, 500000));
    write_reg(REG_FALLBACK_FEED, $urandom_range(1000, 500000));
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_segment(rand_segment(1'b1));
    drain();
  endtask

  // Back to back on both sides to finish.
  task automatic test_streaming();
    idle_on = 1'b0;
    send_random_paths(60);
    drain();
  endtask

  // Receiver: random stall bursts, the long hold-off on request, or ready.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result checker: every summary handed over is compared with the oldest
  // prediction.
  always @(posedge clk) begin
    summary_t exp_s;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_summaries.size() == 0) begin
        $error("unexpected summary: time %0d", out_ch.total_time_ms);
        n_err++;
      end else begin
        exp_s = pending_summaries.pop_front();
        n_checked++;
        if (out_ch.total_time_ms !== exp_s.dur_ms) begin
          $error("total_time_ms: expected %0d, got %0d", exp_s.dur_ms,
                 out_ch.total_time_ms);
          n_err++;
        end
        if (out_ch.min_x !== exp_s.min_x) begin
          $error("min_x: expected %0d, got %0d", exp_s.min_x, out_ch.min_x);
          n_err++;
        end
        if (out_ch.min_y !== exp_s.min_y) begin
          $error("min_y: expected %0d, got %0d", exp_s.min_y, out_ch.min_y);
          n_err++;
        end
        if (out_ch.max_x !== exp_s.max_x) begin
          $error("max_x: expected %0d, got %0d", exp_s.max_x, out_ch.max_x);
          n_err++;
        end
        if (out_ch.max_y !== exp_s.max_y) begin
          $error("max_y: expected %0d, got %0d", exp_s.max_y, out_ch.max_y);
          n_err++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.start_x      <= '0;
    in_ch.start_y      <= '0;
    in_ch.end_x        <= '0;
    in_ch.end_y        <= '0;
    in_ch.center_x     <= '0;
    in_ch.center_y     <= '0;
    in_ch.is_arc       <= 1'b0;
    in_ch.clockwise    <= 1'b0;
    in_ch.is_rapid     <= 1'b0;
    in_ch.feed         <= '0;
    in_ch.last_segment <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    rapid_rate_q = '0;
    fallback_q   = '0;
    clear_job();
    n_err     = 0;
    n_seg     = 0;
    n_paths   = 0;
    n_checked = 0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_settings();
    test_backpressure();
    test_streaming();

    if (pending_summaries.size() != 0) begin
      $error("%0d summaries never arrived", pending_summaries.size());
      n_err++;
    end
    $display("Sent %0d segments in %0d toolpaths; %0d summaries checked.",
             n_seg, n_paths, n_checked);
    $display("Covered lines, arcs, rate fallback, saturation and a long stall.");
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
